[hdl/assert_macros.svh]
// Assertion macros used by the checker file sne_port_chk.sv of this project.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent must too.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[hdl/sne_pkg.sv]
// Shared types, constants and the sigmoid table for the sigmoid neuron core.
// No dependencies; used by sne_ctrl, sne_dpath, sigmoid_neuron_eval_core and sne_port_chk.
package sne_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int ZSPAN_SHIFT   = 18;
   localparam int MAG_W         = 20;
   localparam int T_W           = MAG_W + $clog2(TABLE_ENTRIES);
   localparam int GAIN_NUM      = 31;
   localparam int GAIN_DEN      = 10;
   localparam int ZSPAN         = 4;
   localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
   localparam logic signed [33:0] ZCLAMP_POS = 34'sd524288;
   localparam logic signed [33:0] ZCLAMP_NEG = -34'sd524288;

   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] weight;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [15:0] activation;
      logic        sum_saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FINISH,
      ST_ZCLAMP,
      ST_LOOKUP,
      ST_INTERP
   } state_type;

   typedef struct packed {
      logic take;
      logic z_en;
      logic lut_en;
      logic out_en;
   } cmd_type;

   typedef logic [15:0] rom_type [0:TABLE_ENTRIES];

   // Restoring long division on 64-bit unsigned values; only used while the
   // table is built at elaboration.
   function automatic logic [63:0] sne_udiv64(input logic [63:0] num,
                                              input logic [63:0] dvs);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, dvs}) begin
            rem    = rem - {1'b0, dvs};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Table of round(65535/(1+exp(-3.1*u))) for u evenly spaced over [0, 4].
   // Built at elaboration in 64-bit integer arithmetic with wraparound,
   // exp(-x) as exp(-1)^k times a 20-term series in the fraction.
   function automatic rom_type sne_rom_build();
      rom_type           rom;
      logic [63:0]       x;
      logic [63:0]       k;
      logic [63:0]       r;
      logic [63:0]       term;
      logic [63:0]       whole;
      logic [63:0]       enx;
      logic [63:0]       den;
      logic [63:0]       j;
      longint signed     sum;
      int                i;
      int                n;
      for (i = 0; i <= TABLE_ENTRIES; i++) begin
         x     = sne_udiv64(64'(GAIN_NUM * ZSPAN * i) << 32, 64'(GAIN_DEN * TABLE_ENTRIES));
         k     = x >> 32;
         r     = x & 64'h0000_0000_FFFF_FFFF;
         term  = 64'd1 << 32;
         whole = 64'd1 << 32;
         sum   = 64'sd1 << 32;
         for (n = 1; n <= 20; n++) begin
            term = sne_udiv64((term * r) >> 32, 64'(n));
            if ((n & 1) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         for (j = 64'd0; j < k; j++) begin
            whole = (whole * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
         end
         enx    = (64'(sum) * whole + (64'd1 << 31)) >> 32;
         den    = (64'd1 << 32) + enx;
         rom[i] = 16'(sne_udiv64(64'd65535 * (64'd1 << 32) + (den >> 1), den));
      end
      return rom;
   endfunction

   localparam rom_type SIG_ROM = sne_rom_build();

endpackage

[hdl/sigmoid_neuron_eval_core.sv]
// Top level of the sigmoid neuron core: bias register, controller and datapath.
// Depends on sne_pkg, sne_ctrl and sne_dpath.
//
// Usage:
//   Stream one input vector on the req_ channel, one sample/weight pair per
//   transaction, with last set on the final pair. A transaction is taken at a
//   rising edge with req_valid high and req_stall low. While a vector streams
//   the core takes one transaction per cycle (one 16x16 multiplier feeding a
//   saturating 32-bit accumulator).
//   After the transaction marked last, req_stall stays high while the finish
//   sequence runs: drain the product register, clamp z, read the sigmoid
//   table, interpolate; the result then shows on rsp_valid/rsp_data.
//   The result sits in an output register; the core takes the next vector
//   while it waits. If the receiver still holds rsp_stall high when the next
//   result is ready, the core holds in the interpolate step with req_stall
//   high until the old result is taken.
//   csr_wr_en/csr_wr_data write the signed Q8.8 bias; write only while idle.
//   Synchronous reset clears the bias to zero, the accumulator, the saturation
//   flag and rsp_valid, and returns the controller to accumulate.
module sigmoid_neuron_eval_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sne_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sne_pkg::rsp_type        rsp_data,
   input  logic                    csr_wr_en,
   input  logic signed [15:0]      csr_wr_data
);

   logic signed [15:0] bias_ff, bias_in;
   sne_pkg::cmd_type   cmd;

   // hold the bias until the next write
   always_comb begin
      bias_in = csr_wr_en ? csr_wr_data : bias_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else begin
         bias_ff <= bias_in;
      end
   end

   sne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sne_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .bias     (bias_ff),
      .rsp_data (rsp_data)
   );

endmodule

[hdl/sne_ctrl.sv]
// Controller state machine for the sigmoid neuron core.
// Depends on sne_pkg; drives commands into sne_dpath and owns the result valid.
module sne_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sne_pkg::cmd_type cmd
);

   sne_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sne_pkg::ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         sne_pkg::ST_ACCUM: begin
            req_stall = reset;
            cmd.take  = req_valid && !reset;
            if (cmd.take && req_last) begin
               state_in = sne_pkg::ST_FINISH;
            end
         end
         sne_pkg::ST_FINISH: begin
            state_in = sne_pkg::ST_ZCLAMP;
         end
         sne_pkg::ST_ZCLAMP: begin
            cmd.z_en = 1'b1;
            state_in = sne_pkg::ST_LOOKUP;
         end
         sne_pkg::ST_LOOKUP: begin
            cmd.lut_en = 1'b1;
            state_in   = sne_pkg::ST_INTERP;
         end
         sne_pkg::ST_INTERP: begin
            // wait here while the previous result is still held
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_en = 1'b1;
               state_in   = sne_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = sne_pkg::ST_ACCUM;
         end
      endcase
      rsp_valid_in = cmd.out_en || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/sne_dpath.sv]
// Datapath for the sigmoid neuron core: multiply, saturating accumulate, clamp,
// table lookup and interpolation. Depends on sne_pkg; commanded by sne_ctrl.
module sne_dpath (
   input  logic               clock,
   input  logic               reset,
   input  sne_pkg::cmd_type   cmd,
   input  sne_pkg::req_type   req_data,
   input  logic signed [15:0] bias,
   output sne_pkg::rsp_type   rsp_data
);

   localparam int IDXH_W = sne_pkg::T_W - sne_pkg::ZSPAN_SHIFT;

   // product stage
   logic signed [31:0] prod_ff;
   logic               prod_vld_ff;
   logic               prod_last_ff;

   // accumulator stage
   logic signed [31:0] acc_ff, acc_in;
   logic               ovf_ff;
   logic               ovf_now;
   logic signed [32:0] sum_wide;
   logic signed [31:0] fin_ff;
   logic               fin_ovf_ff;

   // clamp stage
   logic signed [33:0] z_wide;
   logic signed [33:0] z_clamped;
   logic [sne_pkg::MAG_W-1:0] mag_ff;
   logic               neg_ff;

   // lookup stage
   logic [sne_pkg::T_W-1:0]   t_val;
   logic [IDXH_W-1:0]         idx_hi;
   logic                      over;
   logic [sne_pkg::IDX_W-1:0] ia;
   logic [sne_pkg::IDX_W-1:0] ib;
   logic [15:0]               rom_a;
   logic [15:0]               rom_b;
   logic [15:0]               a_ff;
   logic [15:0]               b_ff;
   logic [sne_pkg::ZSPAN_SHIFT-1:0] frac_ff;
   logic                      over_ff;

   // interpolation
   logic [15:0]               diff;
   logic [33:0]               step;
   logic [16:0]               pos_wide;
   logic [15:0]               pos;
   logic [15:0]               act;
   sne_pkg::rsp_type          rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.take;
      end
      if (cmd.take) begin
         prod_ff      <= req_data.sample * req_data.weight;
         prod_last_ff <= req_data.last;
      end
   end

   always_comb begin
      sum_wide = {acc_ff[31], acc_ff} + {prod_ff[31], prod_ff};
      ovf_now  = (sum_wide[32] != sum_wide[31]);
      if (ovf_now) begin
         acc_in = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         acc_in = sum_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (prod_vld_ff) begin
         if (prod_last_ff) begin
            acc_ff <= '0;
            ovf_ff <= 1'b0;
         end else begin
            acc_ff <= acc_in;
            ovf_ff <= ovf_ff || ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_vld_ff && prod_last_ff) begin
         fin_ff     <= acc_in;
         fin_ovf_ff <= ovf_ff || ovf_now;
      end
   end

   // z = sum - bias in Q16.16, clamped to +/- 8.0
   always_comb begin
      z_wide = {{2{fin_ff[31]}}, fin_ff} - {{10{bias[15]}}, bias, 8'b0};
      if (z_wide > sne_pkg::ZCLAMP_POS) begin
         z_clamped = sne_pkg::ZCLAMP_POS;
      end else if (z_wide < sne_pkg::ZCLAMP_NEG) begin
         z_clamped = sne_pkg::ZCLAMP_NEG;
      end else begin
         z_clamped = z_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.z_en) begin
         neg_ff <= z_clamped[33];
         mag_ff <= z_clamped[33] ? sne_pkg::MAG_W'(-z_clamped)
                                 : sne_pkg::MAG_W'(z_clamped);
      end
   end

   always_comb begin
      t_val  = sne_pkg::T_W'(mag_ff) * sne_pkg::T_W'(sne_pkg::TABLE_ENTRIES);
      idx_hi = t_val[sne_pkg::T_W-1:sne_pkg::ZSPAN_SHIFT];
      over   = (idx_hi >= IDXH_W'(sne_pkg::TABLE_ENTRIES));
      ia     = over ? '0 : idx_hi[sne_pkg::IDX_W-1:0];
      ib     = ia + 1'b1;
      rom_a  = sne_pkg::SIG_ROM[ia];
      rom_b  = sne_pkg::SIG_ROM[ib];
   end

   always_ff @(posedge clock) begin
      if (cmd.lut_en) begin
         a_ff    <= rom_a;
         b_ff    <= (rom_b < rom_a) ? rom_a : rom_b;
         frac_ff <= t_val[sne_pkg::ZSPAN_SHIFT-1:0];
         over_ff <= over;
      end
   end

   always_comb begin
      diff     = b_ff - a_ff;
      step     = 34'(diff) * 34'(frac_ff) + (34'd1 << (sne_pkg::ZSPAN_SHIFT - 1));
      pos_wide = {1'b0, a_ff} + 17'(step[33:sne_pkg::ZSPAN_SHIFT]);
      pos      = over_ff ? 16'hFFFF : pos_wide[15:0];
      act      = neg_ff ? (16'hFFFF - pos) : pos;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_en) begin
         rsp_ff.activation    <= act;
         rsp_ff.sum_saturated <= fin_ovf_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[hdl/sne_port_chk.sv]
// Port-level assertions for the sigmoid neuron core, bound to the top level.
// Depends on sne_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sne_port_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sne_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sne_pkg::rsp_type rsp_data
);

   // a stalled result keeps its valid and its payload
   `ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   // the finish sequence blocks input right after the last transaction
   `ASSERT_NEXT(a_busy_after_last, clock, reset,
                req_valid && !req_stall && req_data.last, req_stall)
   // a new result only comes out of the finish sequence
   `ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind sigmoid_neuron_eval_core sne_port_chk u_port_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
